// File: rtl/core/tkst_pkg.sv
// ----------------------------------------------------------------------------
// tkst_pkg
// Shared types and codes for the ranked score table: entry layout, item
// kinds, result status codes, sequencer states and the result record.
// ----------------------------------------------------------------------------
package tkst_pkg;

    // item kinds
    localparam logic [1:0] KIND_ADD   = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;

    // result status codes
    localparam logic [2:0] STAT_ADDED   = 3'd0;
    localparam logic [2:0] STAT_DROPPED = 3'd1;
    localparam logic [2:0] STAT_READ_OK = 3'd2;
    localparam logic [2:0] STAT_EMPTY   = 3'd3;
    localparam logic [2:0] STAT_CLEARED = 3'd4;

    typedef struct packed {
        logic [31:0] points;
        logic [63:0] tag;
    } tkst_entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_PROBE,
        ST_SHIFT,
        ST_PLACE,
        ST_FETCH,
        ST_DONE
    } tkst_state_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [6:0]  placed_rank;
        logic [31:0] points;
        logic [63:0] tag;
        logic [6:0]  entry_count;
    } tkst_result_t;

endpackage

// File: rtl/core/top_k_sorted_score_table.sv
// ----------------------------------------------------------------------------
// top_k_sorted_score_table
// Ranked score table holding up to CAPACITY entries ordered by points, highest
// first, equal points in arrival order; add, read-by-rank and clear items.
//
//   channel   | signals                                     | dir
//   ----------+---------------------------------------------+-----
//   item      | item_valid/item_ready, kind, score_points,  | in
//             | name_tag, read_rank                         |
//   result    | result_valid/result_ready, status,          | out
//             | placed_rank, out_points, out_tag,           |
//             | entry_count                                 |
//
// Steps: a clear, an empty-rank read or an unused kind goes from START to DONE;
//   a read hit goes through FETCH; an add to an empty table goes through PLACE;
//   an add to a full table first probes the lowest entry and drops the item
//   unless its points beat that entry; any other add moves entries down in
//   SHIFT until the compare stops the walk above its rank, then places. The
//   single write port of the entry store, moving one entry per cycle, sets the
//   pace. The result beat is registered in the output register once it is free.
// Reset: the entry count goes to zero; the store itself is not swept.
// Stalls: a new item is taken while a result beat still waits at the output;
//   that item completes only after the waiting beat is taken.
// ----------------------------------------------------------------------------
module top_k_sorted_score_table #(
    parameter int CAPACITY = 100
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_ready,
    input  logic [1:0]  kind,
    input  logic [31:0] score_points,
    input  logic [63:0] name_tag,
    input  logic [6:0]  read_rank,
    output logic        result_valid,
    input  logic        result_ready,
    output logic [2:0]  status,
    output logic [6:0]  placed_rank,
    output logic [31:0] out_points,
    output logic [63:0] out_tag,
    output logic [6:0]  entry_count
);
    import tkst_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    logic          seq_idle;
    logic          start;
    logic          ram_wr_en;
    logic [AW-1:0] ram_wr_addr;
    tkst_entry_t   ram_wr_data;
    logic          ram_rd_en;
    logic [AW-1:0] ram_rd_addr;
    tkst_entry_t   ram_rd_data;
    logic          res_valid;
    tkst_result_t  res;
    logic          res_take;

    logic          out_valid_reg, out_valid_next;
    tkst_result_t  out_reg;

    // take an item only while the sequencer sits idle
    assign item_ready = seq_idle;
    assign start      = item_valid && item_ready;

    tkst_seq #(
        .CAPACITY (CAPACITY),
        .AW       (AW),
        .CW       (CW)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .kind         (kind),
        .score_points (score_points),
        .name_tag     (name_tag),
        .read_rank    (read_rank),
        .idle         (seq_idle),
        .ram_wr_en    (ram_wr_en),
        .ram_wr_addr  (ram_wr_addr),
        .ram_wr_data  (ram_wr_data),
        .ram_rd_en    (ram_rd_en),
        .ram_rd_addr  (ram_rd_addr),
        .ram_rd_data  (ram_rd_data),
        .res_valid    (res_valid),
        .res          (res),
        .res_take     (res_take)
    );

    tkst_ram #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // move a finished result into the output register once it is free
    // or being emptied this cycle
    assign res_take = res_valid && (!out_valid_reg || result_ready);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_take)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            // drop the beat once taken
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // hold the payload while the beat waits
    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            out_reg <= res;
        end
    end

    assign result_valid = out_valid_reg;
    assign status       = out_reg.status;
    assign placed_rank  = out_reg.placed_rank;
    assign out_points   = out_reg.points;
    assign out_tag      = out_reg.tag;
    assign entry_count  = out_reg.entry_count;

endmodule

// File: rtl/core/tkst_ram.sv
// ----------------------------------------------------------------------------
// tkst_ram
// Entry store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tkst_ram #(
    parameter int DEPTH = 100,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                clk,
    input  logic                wr_en,
    input  logic [AW-1:0]       wr_addr,
    input  tkst_pkg::tkst_entry_t wr_data,
    input  logic                rd_en,
    input  logic [AW-1:0]       rd_addr,
    output tkst_pkg::tkst_entry_t rd_data
);
    import tkst_pkg::*;

    tkst_entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: rtl/core/tkst_seq.sv
// ----------------------------------------------------------------------------
// tkst_seq
// Sequencer for the ranked table: captures an item, walks the store from the
// bottom with one shared points compare, shifts lower entries down one per
// cycle and places the new entry; also serves reads and clears.
// ----------------------------------------------------------------------------
module tkst_seq #(
    parameter int CAPACITY = 100,
    parameter int AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
    parameter int CW       = $clog2(CAPACITY + 1)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [1:0]            kind,
    input  logic [31:0]           score_points,
    input  logic [63:0]           name_tag,
    input  logic [6:0]            read_rank,
    output logic                  idle,
    output logic                  ram_wr_en,
    output logic [AW-1:0]         ram_wr_addr,
    output tkst_pkg::tkst_entry_t ram_wr_data,
    output logic                  ram_rd_en,
    output logic [AW-1:0]         ram_rd_addr,
    input  tkst_pkg::tkst_entry_t ram_rd_data,
    output logic                  res_valid,
    output tkst_pkg::tkst_result_t res,
    input  logic                  res_take
);
    import tkst_pkg::*;

    localparam int XW = (CW > 7) ? CW : 7;

    tkst_state_t state_reg, state_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [CW-1:0] filled_reg, filled_next;
    logic [1:0]    kind_reg, kind_next;
    logic [31:0]   pts_reg, pts_next;
    logic [63:0]   tag_reg, tag_next;
    logic [6:0]    rank_reg, rank_next;
    logic [2:0]    status_reg, status_next;

    logic full;
    logic rank_ok;
    logic less;

    assign full    = (filled_reg == CW'(CAPACITY));
    assign rank_ok = (XW'(rank_reg) < XW'(filled_reg));
    // shared compare: stored entry strictly below the new points
    assign less    = (ram_rd_data.points < pts_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                case (kind_reg)
                    KIND_ADD:
                    begin
                        if (full)
                        begin
                            state_next = ST_PROBE;
                        end
                        else if (filled_reg == '0)
                        begin
                            state_next = ST_PLACE;
                        end
                        else
                        begin
                            state_next = ST_SHIFT;
                        end
                    end
                    KIND_READ:
                    begin
                        state_next = rank_ok ? ST_FETCH : ST_DONE;
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_PROBE:
            begin
                if (!less)
                begin
                    state_next = ST_DONE;
                end
                else if (idx_reg == '0)
                begin
                    state_next = ST_PLACE;
                end
                else
                begin
                    state_next = ST_SHIFT;
                end
            end
            ST_SHIFT:
            begin
                if (less && (idx_reg > AW'(1)))
                begin
                    state_next = ST_SHIFT;
                end
                else
                begin
                    state_next = ST_PLACE;
                end
            end
            ST_PLACE:
            begin
                state_next = ST_DONE;
            end
            ST_FETCH:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (res_take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath control
    always_comb
    begin
        idx_next    = idx_reg;
        filled_next = filled_reg;
        kind_next   = kind_reg;
        pts_next    = pts_reg;
        tag_next    = tag_reg;
        rank_next   = rank_reg;
        status_next = status_reg;
        ram_wr_en   = 1'b0;
        ram_wr_addr = idx_reg;
        ram_wr_data = ram_rd_data;
        ram_rd_en   = 1'b0;
        ram_rd_addr = idx_reg - AW'(1);
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    kind_next = kind;
                    pts_next  = score_points;
                    tag_next  = name_tag;
                    rank_next = read_rank;
                end
            end
            ST_START:
            begin
                case (kind_reg)
                    KIND_ADD:
                    begin
                        if (full)
                        begin
                            // look at the lowest entry first
                            ram_rd_en   = 1'b1;
                            ram_rd_addr = AW'(CAPACITY - 1);
                            idx_next    = AW'(CAPACITY - 1);
                        end
                        else
                        begin
                            idx_next = AW'(filled_reg);
                            if (filled_reg != '0)
                            begin
                                ram_rd_en   = 1'b1;
                                ram_rd_addr = AW'(filled_reg - CW'(1));
                            end
                        end
                    end
                    KIND_READ:
                    begin
                        if (rank_ok)
                        begin
                            ram_rd_en   = 1'b1;
                            ram_rd_addr = AW'(rank_reg);
                        end
                        else
                        begin
                            status_next = STAT_EMPTY;
                        end
                    end
                    KIND_CLEAR:
                    begin
                        filled_next = '0;
                        status_next = STAT_CLEARED;
                    end
                    default:
                    begin
                        status_next = STAT_EMPTY;
                    end
                endcase
            end
            ST_PROBE:
            begin
                if (!less)
                begin
                    status_next = STAT_DROPPED;
                end
                else if (idx_reg != '0)
                begin
                    ram_rd_en = 1'b1;
                end
            end
            ST_SHIFT:
            begin
                if (less)
                begin
                    // move the entry above down one rank
                    ram_wr_en = 1'b1;
                    idx_next  = idx_reg - AW'(1);
                    if (idx_reg > AW'(1))
                    begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = idx_reg - AW'(2);
                    end
                end
            end
            ST_PLACE:
            begin
                ram_wr_en          = 1'b1;
                ram_wr_data.points = pts_reg;
                ram_wr_data.tag    = tag_reg;
                status_next        = STAT_ADDED;
                if (!full)
                begin
                    filled_next = filled_reg + CW'(1);
                end
            end
            ST_FETCH:
            begin
                pts_next    = ram_rd_data.points;
                tag_next    = ram_rd_data.tag;
                status_next = STAT_READ_OK;
            end
            ST_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            filled_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            filled_reg <= filled_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        kind_reg   <= kind_next;
        pts_reg    <= pts_next;
        tag_reg    <= tag_next;
        rank_reg   <= rank_next;
        status_reg <= status_next;
    end

    assign idle      = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);

    always_comb
    begin
        res.status      = status_reg;
        res.placed_rank = (status_reg == STAT_ADDED) ? 7'(idx_reg) : 7'd0;
        res.points      = (status_reg == STAT_READ_OK) ? pts_reg : 32'd0;
        res.tag         = (status_reg == STAT_READ_OK) ? tag_reg : 64'd0;
        res.entry_count = 7'(filled_reg);
    end

`ifndef SYNTH
    a_filled_bound: assert property (@(posedge clk) disable iff (!rst_n)
        filled_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_port_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_wr_en && ram_rd_en) |-> (ram_wr_addr != ram_rd_addr))
        else $error("read and write hit the same entry");

    a_shift_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SHIFT) |-> (idx_reg != '0))
        else $error("shift step at top rank");

    a_place_grow: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PLACE && !full) |=> (filled_reg == $past(filled_reg) + CW'(1)))
        else $error("placed entry not counted");
`endif

endmodule

// File: dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the ranked score table. A queue of add, read, clear
// and unused-kind beats feeds a falling-edge driver; a rising-edge monitor
// keeps its own copy of the table, works out each result as the item beat is
// taken, and checks every result beat field by field in arrival order.
// ----------------------------------------------------------------------------
module tb;
    import tkst_pkg::*;

    localparam int          TABLE_DEPTH = 100;
    localparam logic [1:0]  KIND_SPARE  = 2'd3;   // unused kind, must come back as empty
    localparam int          RANDOM_ITEMS = 1200;
    localparam int          SETTLE_CYCLES = 150;  // longest add plus output handoff

    typedef struct {
        logic [1:0]  kind;
        logic [31:0] points;
        logic [63:0] tag;
        logic [6:0]  rank;
        bit          hold_until_idle;
    } score_item_t;

    // ------------------------------------------------------------------
    // DUT signals; every input starts at a known value
    // ------------------------------------------------------------------
    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        item_valid   = 1'b0;
    logic        item_ready;
    logic [1:0]  kind         = KIND_ADD;
    logic [31:0] score_points = '0;
    logic [63:0] name_tag     = '0;
    logic [6:0]  read_rank    = '0;
    logic        result_valid;
    logic        result_ready = 1'b0;
    logic [2:0]  status;
    logic [6:0]  placed_rank;
    logic [31:0] out_points;
    logic [63:0] out_tag;
    logic [6:0]  entry_count;

    top_k_sorted_score_table #(
        .CAPACITY     (TABLE_DEPTH)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .kind         (kind),
        .score_points (score_points),
        .name_tag     (name_tag),
        .read_rank    (read_rank),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .status       (status),
        .placed_rank  (placed_rank),
        .out_points   (out_points),
        .out_tag      (out_tag),
        .entry_count  (entry_count)
    );

    // ------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------
    score_item_t  pending_items[$];   // item beats still to be driven
    tkst_result_t owed_results[$];    // results predicted, not yet seen
    logic         item_fired = 1'b0;  // item beat taken at the last rising edge
    bit           queue_hold = 1'b0;  // mark the next queued beat as a drain point
    int           items_taken = 0;
    int           fault_count = 0;

    // our copy of the table
    logic [31:0]  board_points [TABLE_DEPTH];
    logic [63:0]  board_tags   [TABLE_DEPTH];
    int           board_fill = 0;

    // tallies for the closing summary
    int n_added, n_dropped, n_read_ok, n_empty, n_cleared, n_spare, n_full_seen;

    // no idling on either side while this window of items goes through
    wire calm_window = (items_taken >= 500) && (items_taken < 700);

    // ------------------------------------------------------------------
    // Clock and reset
    // ------------------------------------------------------------------
    initial
    begin
        forever #6 clk = ~clk;
    end

    initial
    begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // ------------------------------------------------------------------
    // Table predictor: apply one item beat to our copy of the table and
    // return the result beat it must produce.
    // ------------------------------------------------------------------
    function automatic tkst_result_t apply_to_table(input logic [1:0]  k,
                                                     input logic [31:0] pts,
                                                     input logic [63:0] tag,
                                                     input logic [6:0]  rank);
        tkst_result_t res;
        int           pos;
        int           last;
        res = '0;
        case (k)
            KIND_ADD:
            begin
                // Find the first slot holding strictly fewer points; ties stay above.
                pos = 0;
                while (pos < board_fill && board_points[pos] >= pts)
                    pos++;
                if (pos >= TABLE_DEPTH)
                begin
                    res.status = STAT_DROPPED;
                end
                else
                begin
                    // Shift the tail down one; on a full table the lowest falls off.
                    last = (board_fill < TABLE_DEPTH) ? board_fill : TABLE_DEPTH - 1;
                    for (int i = last; i > pos; i--)
                    begin
                        board_points[i] = board_points[i - 1];
                        board_tags[i]   = board_tags[i - 1];
                    end
                    board_points[pos] = pts;
                    board_tags[pos]   = tag;
                    if (board_fill < TABLE_DEPTH)
                        board_fill++;
                    res.status      = STAT_ADDED;
                    res.placed_rank = 7'(pos);
                end
            end
            KIND_READ:
            begin
                if (int'(rank) < board_fill)
                begin
                    res.status = STAT_READ_OK;
                    res.points = board_points[rank];
                    res.tag    = board_tags[rank];
                end
                else
                begin
                    res.status = STAT_EMPTY;
                end
            end
            KIND_CLEAR:
            begin
                board_fill = 0;
                res.status = STAT_CLEARED;
            end
            default:
            begin
                res.status = STAT_EMPTY;
            end
        endcase
        res.entry_count = 7'(board_fill);
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Driver: change inputs on the falling edge only. Hold a beat until it
    // is taken; idle now and then; stall before drain points until every
    // owed result has come back.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        score_item_t nxt;
        bit          go;
        if (!rst_n)
        begin
            item_valid   <= 1'b0;
            result_ready <= 1'b0;
        end
        else
        begin
            result_ready <= calm_window || ($urandom_range(99) >= 15);
            if (!item_valid || item_fired)
            begin
                go = (pending_items.size() != 0);
                if (go && pending_items[0].hold_until_idle && owed_results.size() != 0)
                    go = 1'b0;
                if (go && !calm_window && $urandom_range(99) < 15)
                    go = 1'b0;
                if (go)
                begin
                    nxt = pending_items.pop_front();
                    kind         <= nxt.kind;
                    score_points <= nxt.points;
                    name_tag     <= nxt.tag;
                    read_rank    <= nxt.rank;
                end
                item_valid <= go;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: sample both channels on the rising edge. Check the result
    // beat first (it always belongs to an older item), then predict for
    // any item beat taken at this edge.
    // ------------------------------------------------------------------
    task automatic check_field(input string what, input logic [63:0] want_v,
                               input logic [63:0] got_v);
        if (got_v !== want_v)
        begin
            fault_count++;
            if (fault_count <= 10)
                $display("%0t: %s mismatch: expected %0h, got %0h",
                         $realtime, what, want_v, got_v);
        end
    endtask

    always @(posedge clk)
    begin
        tkst_result_t want;
        item_fired <= rst_n && item_valid && item_ready;
        if (rst_n && result_valid && result_ready)
        begin
            if (owed_results.size() == 0)
            begin
                fault_count++;
                if (fault_count <= 10)
                    $display("%0t: result beat with nothing owed: status %0d",
                             $realtime, status);
            end
            else
            begin
                want = owed_results.pop_front();
                check_field("status",      64'(want.status),      64'(status));
                check_field("placed_rank", 64'(want.placed_rank), 64'(placed_rank));
                check_field("out_points",  64'(want.points),      64'(out_points));
                check_field("out_tag",     want.tag,              out_tag);
                check_field("entry_count", 64'(want.entry_count), 64'(entry_count));
                case (want.status)
                    STAT_ADDED:   n_added++;
                    STAT_DROPPED: n_dropped++;
                    STAT_READ_OK: n_read_ok++;
                    STAT_EMPTY:   n_empty++;
                    default:      n_cleared++;
                endcase
                if (want.entry_count == 7'(TABLE_DEPTH))
                    n_full_seen++;
            end
        end
        if (rst_n && item_valid && item_ready)
        begin
            if (kind == KIND_SPARE)
                n_spare++;
            owed_results = {owed_results,
                            apply_to_table(kind, score_points, name_tag, read_rank)};
            items_taken++;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic queue_item(input logic [1:0] k, input logic [31:0] pts,
                              input logic [63:0] tag, input logic [6:0] rank);
        score_item_t it;
        it.kind            = k;
        it.points          = pts;
        it.tag             = tag;
        it.rank            = rank;
        it.hold_until_idle = queue_hold;
        queue_hold         = 1'b0;
        pending_items      = {pending_items, it};
    endtask

    // Mix wide values with a narrow band so ties and drops at a full table happen.
    function automatic logic [31:0] pick_points();
        int roll;
        roll = $urandom_range(99);
        if (roll < 40)
            return $urandom;
        else if (roll < 75)
            return 32'($urandom_range(15));
        else if (roll < 85)
            return ($urandom_range(1)) ? 32'hFFFF_FFFF : 32'h0;
        else
            return 32'hFFFF_FFF0 | 32'($urandom_range(15));
    endfunction

    function automatic logic [63:0] pick_tag();
        return {$urandom, $urandom};
    endfunction

    initial
    begin
        int queued;
        int roll;
        int span;
        int start;
        int next_drain;

        // Directed: empty table, extremes, ties, reads past the fill, unused kind.
        queue_item(KIND_CLEAR, $urandom, pick_tag(), 7'h7F);
        queue_item(KIND_READ,  32'h0, 64'h0, 7'd0);
        queue_item(KIND_SPARE, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 7'h7F);
        queue_item(KIND_ADD,   32'h0, 64'h0, 7'h7F);
        queue_item(KIND_ADD,   32'd5, 64'h4141_4141_4141_4141, 7'd0);
        queue_item(KIND_ADD,   32'd5, 64'h4242_4242_4242_4242, 7'd0);
        queue_item(KIND_ADD,   32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 7'd0);
        queue_item(KIND_ADD,   32'hFFFF_FFFF, 64'h5A5A_A5A5_0F0F_F0F0, 7'd0);
        queue_item(KIND_ADD,   32'd5, 64'h4343_4343_4343_4343, 7'd0);
        for (int r = 0; r <= 6; r++)
            queue_item(KIND_READ, $urandom, pick_tag(), 7'(r));
        queue_item(KIND_READ,  32'h0, 64'h0, 7'd99);
        queue_item(KIND_READ,  32'h0, 64'h0, 7'd100);
        queue_item(KIND_READ,  32'h0, 64'h0, 7'h7F);
        queue_item(KIND_CLEAR, 32'h0, 64'h0, 7'd0);
        queue_item(KIND_READ,  32'h0, 64'h0, 7'd0);
        queue_hold = 1'b1;

        // Random: long fill runs so the table fills and overflows, with
        // scans, rare clears and a little noise in between.
        queued     = 0;
        next_drain = 300;
        while (queued < RANDOM_ITEMS)
        begin
            roll = $urandom_range(99);
            if (roll < 6)
            begin
                queue_item(KIND_CLEAR, $urandom, pick_tag(), 7'($urandom_range(127)));
                queued++;
            end
            else if (roll < 16)
            begin
                span = $urandom_range(1, 6);
                for (int i = 0; i < span; i++)
                begin
                    if ($urandom_range(1))
                        queue_item(KIND_SPARE, $urandom, pick_tag(),
                                   7'($urandom_range(127)));
                    else
                        queue_item(KIND_READ, $urandom, pick_tag(),
                                   7'($urandom_range(127)));
                end
                queued += span;
            end
            else if (roll < 30)
            begin
                span  = $urandom_range(1, 30);
                start = $urandom_range(99);
                for (int i = 0; i < span; i++)
                    queue_item(KIND_READ, $urandom, pick_tag(), 7'(start + i));
                queued += span;
            end
            else
            begin
                span = $urandom_range(40, 150);
                for (int i = 0; i < span; i++)
                begin
                    if ($urandom_range(99) < 20)
                        queue_item(KIND_READ, $urandom, pick_tag(),
                                   7'($urandom_range(99)));
                    else
                        queue_item(KIND_ADD, pick_points(), pick_tag(),
                                   7'($urandom_range(127)));
                end
                queued += span;
            end
            if (queued >= next_drain)
            begin
                queue_hold = 1'b1;
                next_drain += 300;
            end
        end

        // Drain: wait for every beat to go out and every result to return.
        @(posedge clk);
        while (pending_items.size() != 0 || item_valid || owed_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Covered %0d items: %0d adds placed, %0d adds turned away, %0d clears.",
                 items_taken, n_added, n_dropped, n_cleared);
        $display("Reads: %0d hits, %0d empty-rank or unused-kind (%0d unused); full table seen %0d times.",
                 n_read_ok, n_empty, n_spare, n_full_seen);
        if (fault_count == 0 && owed_results.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // ------------------------------------------------------------------
    // Watchdog: far beyond the slowest legal run.
    // ------------------------------------------------------------------
    initial
    begin
        #30_000_000;
        $display("Timeout with %0d results still owed", owed_results.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/tkst_pkg.sv
rtl/core/tkst_ram.sv
rtl/core/tkst_seq.sv
rtl/core/top_k_sorted_score_table.sv
dv/tb.sv
